@@ src/etf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constants for the escape-time fractal pixel block.
// Used by etf_mul, etf_div and escape_time_fractal_pixel; depends on nothing.
package etf_pkg;

  // Number format and fixed field widths
  localparam int FRAC_BITS = 28;
  localparam int SHADE_MAX = 69;
  localparam int COORD_W   = 12;
  localparam int START_W   = 32;
  localparam int CNT_W     = 16;
  localparam int DIM_W     = 12;
  localparam int SHADE_W   = 7;
  localparam int IDX_W     = 3;

  // Datapath widths. z and c stay below 2^14 in magnitude while iterating.
  localparam int NUM_W = COORD_W + 2;          // 3*x or 2*y
  localparam int Z_W   = FRAC_BITS + 16;       // signed z, c
  localparam int H_W   = (Z_W + 1) / 2;        // multiplier operand half
  localparam int M_W   = 2 * H_W;              // operand magnitude
  localparam int ACC_W = 4 * H_W;              // exact product magnitude
  localparam int P_W   = ACC_W - FRAC_BITS + 1; // signed truncated product
  localparam int S_W   = P_W + 1;              // sums of products
  localparam int SH_W  = $clog2(M_W + 1);
  localparam int DVD_W = NUM_W + FRAC_BITS;    // divider dividend
  localparam int DSR_W = CNT_W;                // divider divisor
  localparam int DC_W  = $clog2(DVD_W);
  localparam int NS_W  = CNT_W + SHADE_W;      // count * SHADE_MAX

  localparam logic signed [Z_W-1:0] FX_ONE =
    {{(Z_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [Z_W-1:0] FX_TWO =
    {{(Z_W-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
  localparam logic signed [S_W-1:0] FX_FOUR =
    {{(S_W-FRAC_BITS-3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};
  localparam logic [SHADE_W-1:0] SHADE_TOP = SHADE_W'(SHADE_MAX);

  // Register reset values
  localparam logic [START_W-1:0] RST_START    = '0;
  localparam logic [CNT_W-1:0]   RST_MAX_ITER = 16'd150;
  localparam logic [DIM_W-1:0]   RST_WIDTH    = 12'd236;
  localparam logic [DIM_W-1:0]   RST_HEIGHT   = 12'd59;

  typedef enum logic [IDX_W-1:0] {
    REG_START_RE = 3'd0,
    REG_START_IM = 3'd1,
    REG_MAX_ITER = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } pixel_t;

  typedef struct packed {
    logic [SHADE_W-1:0] shade;
    logic [CNT_W-1:0]   iter_count;
  } pixel_res_t;

  typedef struct packed {
    logic                  start;
    logic signed [Z_W-1:0] a;
    logic signed [Z_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRE_GO,
    S_CRE_WAIT,
    S_CIM_GO,
    S_CIM_WAIT,
    S_LOOP,
    S_RR_GO,
    S_RR_WAIT,
    S_II_GO,
    S_II_WAIT,
    S_TEST,
    S_RI_GO,
    S_RI_WAIT,
    S_SHADE_GO,
    S_SHADE_WAIT,
    S_DONE
  } etf_state_t;

endpackage

@@ src/etf_mul.sv @@
`timescale 1ns / 1ps
// Shared fixed-point multiplier: sign-magnitude, four half-width partial
// products accumulated in turn, truncated toward zero. Uses etf_pkg.
module etf_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  etf_pkg::mul_req_t                 req,
  output etf_pkg::unit_stat_t               stat,
  output logic signed [etf_pkg::P_W-1:0]    product
);

  localparam int ZW = etf_pkg::Z_W;
  localparam int HW = etf_pkg::H_W;
  localparam int MW = etf_pkg::M_W;
  localparam int AW = etf_pkg::ACC_W;
  localparam int PW = etf_pkg::P_W;
  localparam int SW = etf_pkg::SH_W;
  localparam int FB = etf_pkg::FRAC_BITS;

  logic          busy;
  logic          done;
  logic [1:0]    step;
  logic          neg;
  logic [MW-1:0] ma;
  logic [MW-1:0] mb;
  logic [AW-1:0] acc;

  logic [ZW-1:0] a_abs;
  logic [ZW-1:0] b_abs;
  logic [HW-1:0] a_half;
  logic [HW-1:0] b_half;
  logic [MW-1:0] pp;
  logic [SW-1:0] sh;
  logic [AW-1:0] pp_sh;
  logic [AW-1:0] acc_next;
  logic signed [PW-1:0] mag;

  // operand magnitudes at start
  assign a_abs = req.a[ZW-1] ? ZW'(-req.a) : ZW'(req.a);
  assign b_abs = req.b[ZW-1] ? ZW'(-req.b) : ZW'(req.b);

  // step[0] picks the half of a, step[1] the half of b
  assign a_half   = step[0] ? ma[MW-1:HW] : ma[HW-1:0];
  assign b_half   = step[1] ? mb[MW-1:HW] : mb[HW-1:0];
  assign pp       = a_half * b_half;
  assign sh       = (step[0] ? SW'(HW) : SW'(0)) + (step[1] ? SW'(HW) : SW'(0));
  assign pp_sh    = AW'(pp) << sh;
  assign acc_next = acc + pp_sh;

  // truncate magnitude, then apply sign
  assign mag     = {1'b0, acc[AW-1:FB]};
  assign product = neg ? -mag : mag;

  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'b00;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'b00;
      end else if (busy) begin
        step <= step + 2'b01;
        if (&step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.a[ZW-1] ^ req.b[ZW-1];
      ma  <= MW'(a_abs);
      mb  <= MW'(b_abs);
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

endmodule

@@ src/etf_div.sv @@
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle over the full dividend
// width. Used for coordinate mapping and the shade index. Uses etf_pkg.
module etf_div (
  input  logic                           clk,
  input  logic                           rst,
  input  etf_pkg::div_req_t              req,
  output etf_pkg::unit_stat_t            stat,
  output logic [etf_pkg::DVD_W-1:0]      quotient
);

  localparam int QW = etf_pkg::DVD_W;
  localparam int DW = etf_pkg::DSR_W;
  localparam int CW = etf_pkg::DC_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [QW-1:0] q;
  logic [DW-1:0] r;
  logic [DW-1:0] den;

  logic [DW:0]   r_sh;
  logic [DW:0]   r_sub;
  logic          fits;

  // shift in the next dividend bit, subtract when it fits
  assign r_sh  = {r, q[QW-1]};
  assign r_sub = r_sh - {1'b0, den};
  assign fits  = r_sh >= {1'b0, den};

  assign quotient  = q;
  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.dividend;
      r   <= '0;
      den <= req.divisor;
    end else if (busy) begin
      q <= {q[QW-2:0], fits};
      r <= fits ? r_sub[DW-1:0] : r_sh[DW-1:0];
    end
  end

endmodule

@@ src/escape_time_fractal_pixel.sv @@
`timescale 1ns / 1ps
// Top level of the escape-time fractal pixel block: sequencer, registers,
// result register. Depends on etf_pkg, etf_mul and etf_div.
//
// Usage:
//   pix carries one pixel (x_coord, y_coord); a beat moves when pix_valid is
//   high and pix_stall is low. res carries (shade, iter_count); a beat moves
//   when res_valid is high and res_stall is low. cfg writes one register per
//   beat (cfg_index, cfg_data); cfg_ready is always high.
//   Each pixel maps x and y to c through the shared restoring divider, one
//   quotient bit per cycle, then runs z = z*z + c on the shared
//   multiplier: three products of four partial products each per
//   iteration. The shade index takes one more divider pass unless max_iter
//   is 0.
//   One pixel is in work at a time; pix_stall is low only while idle.
//   The result sits in an output register, so a new pixel is taken while the
//   previous result waits; a finished pixel holds until that register frees.
//   Reset (rst, synchronous) empties the block and sets start_re and
//   start_im to 0, max_iter to 150, image_width to 236, image_height to 59.
module escape_time_fractal_pixel (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  etf_pkg::pixel_t                    pix,
  output logic                               res_valid,
  input  logic                               res_stall,
  output etf_pkg::pixel_res_t                res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [etf_pkg::IDX_W-1:0]          cfg_index,
  input  logic [etf_pkg::START_W-1:0]        cfg_data
);

  localparam int ZW = etf_pkg::Z_W;
  localparam int PW = etf_pkg::P_W;
  localparam int SW = etf_pkg::S_W;
  localparam int QW = etf_pkg::DVD_W;
  localparam int DW = etf_pkg::DSR_W;
  localparam int NW = etf_pkg::NUM_W;
  localparam int CW = etf_pkg::CNT_W;
  localparam int KW = etf_pkg::NS_W;
  localparam int HW = etf_pkg::SHADE_W;
  localparam int FB = etf_pkg::FRAC_BITS;

  // configuration registers
  logic [etf_pkg::START_W-1:0] start_re;
  logic [etf_pkg::START_W-1:0] start_im;
  logic [CW-1:0]               max_iter;
  logic [etf_pkg::DIM_W-1:0]   image_width;
  logic [etf_pkg::DIM_W-1:0]   image_height;

  etf_pkg::etf_state_t state, state_next;

  // working registers
  logic [etf_pkg::COORD_W-1:0] x;
  logic [etf_pkg::COORD_W-1:0] y;
  logic signed [ZW-1:0] cre;
  logic signed [ZW-1:0] cim;
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zi;
  logic signed [PW-1:0] r2;
  logic signed [PW-1:0] i2;
  logic [CW-1:0]        n;
  logic [HW-1:0]        shade_val;

  etf_pkg::mul_req_t   mul_req;
  etf_pkg::unit_stat_t mul_stat;
  logic signed [PW-1:0] mul_p;
  etf_pkg::div_req_t   div_req;
  etf_pkg::unit_stat_t div_stat;
  logic [QW-1:0]       div_q;

  logic                 accept;
  logic                 load;
  logic [NW-1:0]        x3;
  logic [NW-1:0]        y2;
  logic [DW-1:0]        w_eff;
  logic [DW-1:0]        h_eff;
  logic [KW-1:0]        n_scaled;
  logic signed [ZW-1:0] q_fx;
  logic signed [SW-1:0] esc_sum;
  logic signed [SW-1:0] zr_full;
  logic signed [SW-1:0] zi_full;

  etf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .stat    (mul_stat),
    .product (mul_p)
  );

  etf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_re     <= etf_pkg::RST_START;
      start_im     <= etf_pkg::RST_START;
      max_iter     <= etf_pkg::RST_MAX_ITER;
      image_width  <= etf_pkg::RST_WIDTH;
      image_height <= etf_pkg::RST_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (etf_pkg::cfg_reg_t'(cfg_index))
        etf_pkg::REG_START_RE: start_re     <= cfg_data;
        etf_pkg::REG_START_IM: start_im     <= cfg_data;
        etf_pkg::REG_MAX_ITER: max_iter     <= cfg_data[CW-1:0];
        etf_pkg::REG_WIDTH:    image_width  <= cfg_data[etf_pkg::DIM_W-1:0];
        etf_pkg::REG_HEIGHT:   image_height <= cfg_data[etf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // operand formation
  assign x3       = NW'({x, 1'b0}) + NW'(x);
  assign y2       = NW'({y, 1'b0});
  assign w_eff    = (image_width == '0) ? DW'(1) : DW'(image_width);
  assign h_eff    = (image_height == '0) ? DW'(1) : DW'(image_height);
  assign n_scaled = KW'(n) * KW'(etf_pkg::SHADE_MAX);
  assign q_fx     = {{(ZW-QW){1'b0}}, div_q};
  assign esc_sum  = SW'(r2) + SW'(i2);
  assign zr_full  = SW'(r2) - SW'(i2) + SW'(cre);
  assign zi_full  = SW'(mul_p) + SW'(mul_p) + SW'(cim);

  assign pix_stall = (state != etf_pkg::S_IDLE);
  assign accept    = pix_valid && !pix_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit requests
  always_comb begin
    state_next       = state;
    load             = 1'b0;
    mul_req.start    = 1'b0;
    mul_req.a        = zr;
    mul_req.b        = zr;
    div_req.start    = 1'b0;
    div_req.dividend = {x3, {FB{1'b0}}};
    div_req.divisor  = w_eff;
    case (state)
      etf_pkg::S_IDLE: begin
        if (accept) state_next = etf_pkg::S_CRE_GO;
      end
      etf_pkg::S_CRE_GO: begin
        div_req.start = 1'b1;
        state_next    = etf_pkg::S_CRE_WAIT;
      end
      etf_pkg::S_CRE_WAIT: begin
        if (div_stat.done) state_next = etf_pkg::S_CIM_GO;
      end
      etf_pkg::S_CIM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {y2, {FB{1'b0}}};
        div_req.divisor  = h_eff;
        state_next       = etf_pkg::S_CIM_WAIT;
      end
      etf_pkg::S_CIM_WAIT: begin
        if (div_stat.done) state_next = etf_pkg::S_LOOP;
      end
      etf_pkg::S_LOOP: begin
        state_next = (n < max_iter) ? etf_pkg::S_RR_GO : etf_pkg::S_SHADE_GO;
      end
      etf_pkg::S_RR_GO: begin
        mul_req.start = 1'b1;
        state_next    = etf_pkg::S_RR_WAIT;
      end
      etf_pkg::S_RR_WAIT: begin
        if (mul_stat.done) state_next = etf_pkg::S_II_GO;
      end
      etf_pkg::S_II_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = zi;
        mul_req.b     = zi;
        state_next    = etf_pkg::S_II_WAIT;
      end
      etf_pkg::S_II_WAIT: begin
        if (mul_stat.done) state_next = etf_pkg::S_TEST;
      end
      etf_pkg::S_TEST: begin
        state_next = (esc_sum >= etf_pkg::FX_FOUR) ? etf_pkg::S_SHADE_GO
                                                   : etf_pkg::S_RI_GO;
      end
      etf_pkg::S_RI_GO: begin
        mul_req.start = 1'b1;
        mul_req.b     = zi;
        state_next    = etf_pkg::S_RI_WAIT;
      end
      etf_pkg::S_RI_WAIT: begin
        if (mul_stat.done) state_next = etf_pkg::S_LOOP;
      end
      etf_pkg::S_SHADE_GO: begin
        div_req.dividend = QW'(n_scaled);
        div_req.divisor  = max_iter;
        if (max_iter == '0) begin
          state_next = etf_pkg::S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_next    = etf_pkg::S_SHADE_WAIT;
        end
      end
      etf_pkg::S_SHADE_WAIT: begin
        if (div_stat.done) state_next = etf_pkg::S_DONE;
      end
      etf_pkg::S_DONE: begin
        if (!res_valid || !res_stall) begin
          load       = 1'b1;
          state_next = etf_pkg::S_IDLE;
        end
      end
      default: state_next = etf_pkg::S_IDLE;
    endcase
  end

  // working registers, captured on accept and as each unit finishes
  always_ff @(posedge clk) begin
    if (accept) begin
      x <= pix.x_coord;
      y <= pix.y_coord;
    end
    if (state == etf_pkg::S_CRE_WAIT && div_stat.done) begin
      cre <= q_fx - etf_pkg::FX_TWO;
    end
    if (state == etf_pkg::S_CIM_WAIT && div_stat.done) begin
      cim <= q_fx - etf_pkg::FX_ONE;
      zr  <= ZW'(signed'(start_re));
      zi  <= ZW'(signed'(start_im));
      n   <= '0;
    end
    if (state == etf_pkg::S_RR_WAIT && mul_stat.done) r2 <= mul_p;
    if (state == etf_pkg::S_II_WAIT && mul_stat.done) i2 <= mul_p;
    if (state == etf_pkg::S_RI_WAIT && mul_stat.done) begin
      zr <= zr_full[ZW-1:0];
      zi <= zi_full[ZW-1:0];
      n  <= n + CW'(1);
    end
    if (state == etf_pkg::S_SHADE_GO && max_iter == '0) shade_val <= '0;
    if (state == etf_pkg::S_SHADE_WAIT && div_stat.done) shade_val <= div_q[HW-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.shade      <= shade_val;
      res.iter_count <= n;
    end
  end

  // checks
  a_mul_idle_start: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    load |-> n <= max_iter)
    else $error("iteration count past limit");

  a_shade_range: assert property (@(posedge clk) disable iff (rst)
    load |-> shade_val <= etf_pkg::SHADE_TOP)
    else $error("shade index out of range");

endmodule
